>>> rtl/deque_with_search_macros.svh
// Assertion macros shared by the deque RTL.
`ifndef DEQUE_WITH_SEARCH_MACROS_SVH
`define DEQUE_WITH_SEARCH_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DWS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define DWS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/dws_pkg.sv
// Types and constants of the deque with search.
package dws_pkg;

	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;
	localparam int PTR_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int ACT_W      = 3;

	localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_FIND       = 3'd4;

	typedef struct packed {
		logic [ACT_W-1:0]             action;
		logic signed [DATA_WIDTH-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             is_empty;
		logic             is_full;
		logic             rejected;
		logic             found;
		logic [PTR_W-1:0] found_position;
	} res_t;

endpackage

>>> rtl/deque_with_search.sv
// Bounded deque in a ring memory with a front-to-back linear search.
//
//   beat   | direction    | handshake             | payload
//   -------+--------------+-----------------------+-----------------------------
//   cmd    | into block   | cmd_valid / cmd_stall | action, value
//   res    | out of block | res_valid / res_stall | count, flags, found_position
//
// Push, pop, an unused action or a find on an empty deque goes straight to the
// result slot. A find scans from the front, one read a cycle, and stops at the
// first match or after the last entry; cmd stalls while the scan runs.
// Reset clears the front pointer, the count and the valid flags, not the memory.
// A stalled res beat holds in the output register, the next result waits in the
// slot behind it, and cmd stalls until that slot frees.
`include "deque_with_search_macros.svh"

module deque_with_search (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  dws_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output dws_pkg::res_t res
);
	import dws_pkg::*;

	localparam int SUM_W = CNT_W + 1;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	// ring index of base + off, both below DEPTH
	function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(off);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

	// entry store: single write port, registered read
	logic [DATA_WIDTH-1:0] mem [DEPTH];

	// deque state
	logic [PTR_W-1:0] front_q;
	logic [CNT_W-1:0] cnt_q;
	logic             state_q;

	// result slot and output register
	logic slot_vld_q;
	res_t slot_q;
	logic res_vld_q;
	res_t res_q;

	// search machinery
	logic [DATA_WIDTH-1:0] key_q;
	logic [CNT_W-1:0]      scan_idx_q;
	logic                  rd_vld_s1;
	logic [PTR_W-1:0]      rd_pos_s1;
	logic [DATA_WIDTH-1:0] rd_data_s1;

	// command decode
	logic             cmd_acc;
	logic             full_w;
	logic             empty_w;
	logic [PTR_W-1:0] front_d;
	logic [CNT_W-1:0] cnt_d;
	logic             wr_en;
	logic [PTR_W-1:0] wr_addr;
	logic             rej_d;
	logic             start_scan;
	res_t             acc_res;

	// scan control
	logic scan_issue;
	logic hit;
	logic last;
	logic scan_done;
	res_t scan_res;
	logic slot_move;

	assign full_w    = (cnt_q == CNT_W'(DEPTH));
	assign empty_w   = (cnt_q == '0);
	assign cmd_stall = (state_q != ST_IDLE) || slot_vld_q;
	assign cmd_acc   = cmd_valid && !cmd_stall;

	always_comb begin
		front_d    = front_q;
		cnt_d      = cnt_q;
		wr_en      = 1'b0;
		wr_addr    = front_q;
		rej_d      = 1'b0;
		start_scan = 1'b0;
		unique case (cmd.action)
			ACT_PUSH_FRONT: begin
				if (full_w) begin
					rej_d = 1'b1;
				end else begin
					front_d = (front_q == '0) ? PTR_W'(DEPTH - 1) : front_q - PTR_W'(1);
					wr_en   = 1'b1;
					wr_addr = front_d;
					cnt_d   = cnt_q + CNT_W'(1);
				end
			end
			ACT_PUSH_BACK: begin
				if (full_w) begin
					rej_d = 1'b1;
				end else begin
					wr_en   = 1'b1;
					wr_addr = ring_add(front_q, cnt_q);
					cnt_d   = cnt_q + CNT_W'(1);
				end
			end
			ACT_POP_FRONT: begin
				if (!empty_w) begin
					front_d = ring_add(front_q, CNT_W'(1));
					cnt_d   = cnt_q - CNT_W'(1);
				end
			end
			ACT_POP_BACK: begin
				if (!empty_w) begin
					cnt_d = cnt_q - CNT_W'(1);
				end
			end
			ACT_FIND: begin
				start_scan = !empty_w;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		acc_res                = '0;
		acc_res.count          = cnt_d;
		acc_res.is_empty       = (cnt_d == '0);
		acc_res.is_full        = (cnt_d == CNT_W'(DEPTH));
		acc_res.rejected       = rej_d;
	end

	// reads go out one per cycle; the compare runs in the cycle after each read, on the
	// registered read data, so a read past the match is simply discarded
	assign scan_issue = (state_q == ST_SCAN) && (scan_idx_q != cnt_q);
	assign hit        = rd_vld_s1 && (rd_data_s1 == key_q);
	assign last       = rd_vld_s1 && (CNT_W'(rd_pos_s1) == cnt_q - CNT_W'(1));
	assign scan_done  = (state_q == ST_SCAN) && (hit || last);

	always_comb begin
		scan_res                = '0;
		scan_res.count          = cnt_q;
		scan_res.is_empty       = empty_w;
		scan_res.is_full        = full_w;
		scan_res.found          = hit;
		scan_res.found_position = hit ? rd_pos_s1 : '0;
	end

	assign slot_move = slot_vld_q && (!res_vld_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q    <= '0;
			cnt_q      <= '0;
			state_q    <= ST_IDLE;
			slot_vld_q <= 1'b0;
			res_vld_q  <= 1'b0;
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			// output register
			if (slot_move) begin
				res_vld_q <= 1'b1;
			end else if (res_vld_q && !res_stall) begin
				res_vld_q <= 1'b0;
			end
			if (slot_move) begin
				slot_vld_q <= 1'b0;
			end

			// command apply
			if (cmd_acc) begin
				front_q <= front_d;
				cnt_q   <= cnt_d;
				if (start_scan) begin
					state_q    <= ST_SCAN;
					scan_idx_q <= '0;
				end else begin
					slot_vld_q <= 1'b1;
				end
			end

			// search
			if (scan_done) begin
				state_q    <= ST_IDLE;
				slot_vld_q <= 1'b1;
				rd_vld_s1  <= 1'b0;
			end else begin
				rd_vld_s1 <= scan_issue;
				if (scan_issue) begin
					scan_idx_q <= scan_idx_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			key_q <= cmd.value;
		end
		if (cmd_acc && !start_scan) begin
			slot_q <= acc_res;
		end else if (scan_done) begin
			slot_q <= scan_res;
		end
		if (slot_move) begin
			res_q <= slot_q;
		end
		if (scan_issue) begin
			rd_pos_s1 <= scan_idx_q[PTR_W-1:0];
		end
	end

	// entry memory
	always_ff @(posedge clk) begin
		if (cmd_acc && wr_en) begin
			mem[wr_addr] <= cmd.value;
		end
		if (scan_issue) begin
			rd_data_s1 <= mem[ring_add(front_q, scan_idx_q)];
		end
	end

	assign res_valid = res_vld_q;
	assign res       = res_q;

	`DWS_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(DEPTH), "entry count beyond depth")
	`DWS_ASSERT_NEXT(a_scan_hold, state_q == ST_SCAN, $stable(front_q) && $stable(cnt_q), "deque moved during a search")
	`DWS_ASSERT_SAME(a_pos_range, res_valid && res.found, CNT_W'(res.found_position) < res.count, "match position outside stored entries")
	`DWS_ASSERT_SAME(a_empty_flag, res_valid, res.is_empty == (res.count == '0), "empty flag disagrees with count")

endmodule
